[design/fla_pkg.sv]
// Shared types and constants for the free-list block allocator.
// Used by fla_ctrl, fla_dp and free_list_block_allocator; no dependencies.
package fla_pkg;

  // Volume geometry
  localparam int MAX_BLOCKS = 1024;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;

  // Configuration port
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam logic REG_VOLUME_BLOCKS = 1'b0;
  localparam logic [CNT_W-1:0] VOLUME_RESET = CNT_W'(MAX_BLOCKS);

  // Operation codes
  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  // Result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FULL         = 3'd1;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd2;
  localparam logic [2:0] ST_RANGE        = 3'd3;
  localparam logic [2:0] ST_FORMATTED    = 3'd4;
  localparam logic [2:0] ST_UNFORMATTED  = 3'd5;

  // Request word
  typedef struct packed {
    logic [1:0]       opcode;
    logic [BLK_W-1:0] block_index;
  } fla_in_t;

  // Result word
  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic [2:0]       status;
    logic [CNT_W-1:0] blocks_free;
  } fla_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // capture request, launch memory reads
    logic walk;     // write one format entry and advance
    logic commit;   // apply the update and load the result word
  } fla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_req;   // incoming request is a format of an unformatted volume
    logic walk_last;  // the format walk is at the last entry
  } fla_stat_t;

endpackage

[design/fla_ctrl.sv]
// Controller state machine for the free-list block allocator.
// Depends on fla_pkg for the command and status structs.
module fla_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fla_pkg::fla_stat_t stat,
  output fla_pkg::fla_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.walk_req ? S_WALK : S_EXEC;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/fla_dp.sv]
// Datapath of the free-list block allocator: link and mark memories,
// list head, free count, format walk counter and result register. Uses fla_pkg.
module fla_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fla_pkg::fla_cmd_t             cmd,
  output fla_pkg::fla_stat_t            stat,
  input  fla_pkg::fla_in_t              in_data,
  input  logic [fla_pkg::CNT_W-1:0]     volume_blocks,
  output fla_pkg::fla_out_t             out_data
);

  localparam int BW = fla_pkg::BLK_W;
  localparam int CW = fla_pkg::CNT_W;

  // Per-block storage, undefined until the format walk writes it
  logic [BW-1:0] link_mem [fla_pkg::MAX_BLOCKS];
  logic          mark_mem [fla_pkg::MAX_BLOCKS];

  logic [1:0]    op_r;
  logic [BW-1:0] blk_r;
  logic [BW-1:0] head_r, head_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          formatted_r, formatted_nxt;
  logic [BW-1:0] walk_r;
  logic [BW-1:0] rd_link_r;
  logic          rd_mark_r;
  fla_pkg::fla_out_t out_data_r, result;

  logic [CW-1:0] size;
  logic [CW-1:0] walk_ext;
  logic          link_we, mark_we;
  logic [BW-1:0] link_waddr, mark_waddr, link_wdata;
  logic          mark_wdata;

  // Volume size in use, clamped to the supported range
  always_comb begin
    if (volume_blocks < CW'(2)) begin
      size = CW'(2);
    end else if (volume_blocks > CW'(fla_pkg::MAX_BLOCKS)) begin
      size = CW'(fla_pkg::MAX_BLOCKS);
    end else begin
      size = volume_blocks;
    end
  end

  assign walk_ext         = {1'b0, walk_r};
  assign stat.walk_req    = (in_data.opcode == fla_pkg::OP_FORMAT) && !formatted_r;
  assign stat.walk_last   = (walk_ext == size - CW'(1));

  // Operation decode and memory write selection
  always_comb begin
    result        = '0;
    head_nxt      = head_r;
    total_nxt     = total_r;
    formatted_nxt = formatted_r;
    link_we       = 1'b0;
    mark_we       = 1'b0;
    link_waddr    = blk_r;
    mark_waddr    = blk_r;
    link_wdata    = head_r;
    mark_wdata    = 1'b1;

    if (cmd.walk) begin
      // Format walk: entry zero is the superblock, the rest chain in order and the last links to entry zero
      link_we    = 1'b1;
      mark_we    = 1'b1;
      link_waddr = walk_r;
      mark_waddr = walk_r;
      if (walk_r == '0) begin
        link_wdata = '0;
        mark_wdata = 1'b0;
      end else if (walk_ext + CW'(1) == size) begin
        link_wdata = '0;
      end else begin
        link_wdata = walk_r + BW'(1);
      end
    end

    unique case (op_r)
      fla_pkg::OP_FORMAT: begin
        if (formatted_r) begin
          result.status = fla_pkg::ST_FORMATTED;
        end else begin
          result.status = fla_pkg::ST_OK;
          head_nxt      = BW'(1);
          total_nxt     = size - CW'(1);
          formatted_nxt = 1'b1;
        end
      end
      fla_pkg::OP_ALLOC: begin
        if (!formatted_r) begin
          result.status = fla_pkg::ST_UNFORMATTED;
        end else if (total_r == '0) begin
          result.status = fla_pkg::ST_FULL;
        end else begin
          result.status        = fla_pkg::ST_OK;
          result.granted_block = head_r;
          head_nxt             = rd_link_r;
          total_nxt            = total_r - CW'(1);
          if (cmd.commit) begin
            mark_we    = 1'b1;
            mark_waddr = head_r;
            mark_wdata = 1'b0;
          end
        end
      end
      fla_pkg::OP_FREE: begin
        if (!formatted_r) begin
          result.status = fla_pkg::ST_UNFORMATTED;
        end else if ({1'b0, blk_r} >= size) begin
          result.status = fla_pkg::ST_RANGE;
        end else if (rd_mark_r) begin
          result.status = fla_pkg::ST_ALREADY_FREE;
        end else begin
          result.status = fla_pkg::ST_OK;
          head_nxt      = blk_r;
          total_nxt     = total_r + CW'(1);
          if (cmd.commit) begin
            link_we = 1'b1;
            mark_we = 1'b1;
          end
        end
      end
      default: result.status = fla_pkg::ST_RANGE;
    endcase
    result.blocks_free = total_nxt;
  end

  // Link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.accept) begin
      rd_link_r <= link_mem[head_r];
    end
  end

  // Free mark memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (cmd.accept) begin
      rd_mark_r <= mark_mem[in_data.block_index];
    end
  end

  // Request capture, walk counter and result word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_data.opcode;
      blk_r  <= in_data.block_index;
      walk_r <= '0;
    end else if (cmd.walk) begin
      walk_r <= walk_r + BW'(1);
    end
    if (cmd.commit) begin
      out_data_r <= result;
    end
  end

  // List state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      total_r     <= '0;
      formatted_r <= 1'b0;
    end else if (cmd.commit) begin
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      formatted_r <= formatted_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

[design/free_list_block_allocator.sv]
// Top level of the free-list block allocator: configuration register,
// controller and datapath. Depends on fla_pkg, fla_ctrl and fla_dp.
//
//   Channel  Ports                              Carries
//   in       in_valid, in_ready, in_data        opcode, block_index
//   out      out_valid, out_ready, out_data     granted_block, status, blocks_free
//   cfg      psel, penable, pwrite, paddr, ...  volume_blocks at byte address 0
//
// Allocate, free and refused operations read the link and mark memories
// when accepted, then update and load the result register.
// A format of an unformatted volume first walks the memories, one write per block.
// Reset clears the list head, free count and formatted flag; the memories
// are not cleared, the format walk writes them. A full result register
// holds the finished operation in its last cycle until out_ready frees it.
module free_list_block_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fla_pkg::fla_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fla_pkg::fla_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fla_pkg::APB_AW-1:0]     paddr,
  input  logic [fla_pkg::APB_DW-1:0]     pwdata,
  output logic [fla_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  logic [fla_pkg::CNT_W-1:0] volume_blocks_r;
  logic                      reg_sel;
  fla_pkg::fla_cmd_t         cmd;
  fla_pkg::fla_stat_t        stat;

  // Volume size register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[fla_pkg::APB_AW-1] == fla_pkg::REG_VOLUME_BLOCKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_blocks_r <= fla_pkg::VOLUME_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      volume_blocks_r <= pwdata[fla_pkg::CNT_W-1:0];
    end
  end

  // Read back
  assign prdata = reg_sel ? fla_pkg::APB_DW'(volume_blocks_r) : '0;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fla_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (in_data),
    .volume_blocks (volume_blocks_r),
    .out_data      (out_data)
  );

endmodule
